### rtl/core/region_cache_fifo_directory_assert.svh
// assertion macros used by the region cache directory rtl
`ifndef REGION_CACHE_FIFO_DIRECTORY_ASSERT_SVH
`define REGION_CACHE_FIFO_DIRECTORY_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define RCFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define RCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/rcfd_pkg.sv
// shared types and constants of the region cache directory
package rcfd_pkg;

	// threshold register width and reset value
	localparam int unsigned THR_W = 7;
	localparam logic [THR_W-1:0] THR_RESET = 7'd100;

	// reported slot field width
	localparam int unsigned SLOT_OUT_W = 7;

	// configuration port
	localparam int unsigned CFG_AW = 3;
	localparam int unsigned CFG_DW = 32;
	localparam logic [0:0] REG_EVICT_THRESHOLD = 1'b0;

	// request sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_FINISH
	} rcfd_state_t;

	// per-cell update controls
	typedef struct packed {
		logic write;
		logic clear;
		logic is_oldest;
	} cell_ctl_t;

	// flags of the lookup token moving down the chain
	typedef struct packed {
		logic active;
		logic found;
	} tok_flags_t;

endpackage

### rtl/core/rcfd_cell.sv
// one directory cell: stored key, valid mark and one stage of the lookup chain
module rcfd_cell #(
	parameter int KEY_BITS  = 14,
	parameter int SLOT_BITS = 7,
	parameter int IDX       = 0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rcfd_pkg::cell_ctl_t   ctl,
	input  logic [KEY_BITS-1:0]   wr_key,
	input  rcfd_pkg::tok_flags_t  flags_in,
	input  logic [KEY_BITS-1:0]   key_in,
	input  logic [SLOT_BITS-1:0]  slot_in,
	input  logic [KEY_BITS-1:0]   ev_key_in,
	output rcfd_pkg::tok_flags_t  flags_out,
	output logic [KEY_BITS-1:0]   key_out,
	output logic [SLOT_BITS-1:0]  slot_out,
	output logic [KEY_BITS-1:0]   ev_key_out
);
	import rcfd_pkg::*;

	logic                 valid_q;
	logic [KEY_BITS-1:0]  key_q;
	tok_flags_t           flags_q;
	logic [KEY_BITS-1:0]  tok_key_q;
	logic [SLOT_BITS-1:0] tok_slot_q;
	logic [KEY_BITS-1:0]  tok_ev_key_q;
	logic                 match;

	// valid mark: a write wins over a clear of the same cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.write) begin
			valid_q <= 1'b1;
		end else if (ctl.clear) begin
			valid_q <= 1'b0;
		end
	end

	// key storage, undefined until first written
	always_ff @(posedge clk) begin
		if (ctl.write) begin
			key_q <= wr_key;
		end
	end

	// local compare against the passing request
	assign match = valid_q && (key_q == key_in);

	// token flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q.active <= flags_in.active;
			flags_q.found  <= flags_in.found | match;
		end
	end

	// token payload: pick up slot on a match and the oldest key on the way
	always_ff @(posedge clk) begin
		tok_key_q    <= key_in;
		tok_slot_q   <= match ? SLOT_BITS'(IDX) : slot_in;
		tok_ev_key_q <= ctl.is_oldest ? key_q : ev_key_in;
	end

	assign flags_out  = flags_q;
	assign key_out    = tok_key_q;
	assign slot_out   = tok_slot_q;
	assign ev_key_out = tok_ev_key_q;

endmodule

### rtl/core/region_cache_fifo_directory.sv
// top level: fifo-replacement region cache directory built as a chain of cells
// flow: an accepted request sends a lookup token down the cell chain, one cell per cycle;
//   the result and the directory update are registered in the finish state once the result
//   channel is not stalled; requests are taken only while idle, so none is accepted until then
// reset: asynchronous, clears all valid marks, counters and output valid;
//   threshold returns to 100; key storage is not cleared and needs no pass
module region_cache_fifo_directory #(
	parameter int SLOTS    = 128,
	parameter int KEY_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [rcfd_pkg::CFG_AW-1:0]         paddr,
	input  logic [rcfd_pkg::CFG_DW-1:0]         pwdata,
	output logic [rcfd_pkg::CFG_DW-1:0]         prdata,
	output logic                                pready,
	// request channel
	input  logic                                req_valid,
	output logic                                req_stall,
	input  logic [KEY_BITS-1:0]                 region_key,
	input  logic                                load_ok,
	// result channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                hit,
	output logic                                present,
	output logic [rcfd_pkg::SLOT_OUT_W-1:0]     slot,
	output logic                                evicted,
	output logic [KEY_BITS-1:0]                 evicted_key
);
	import rcfd_pkg::*;
	`include "region_cache_fifo_directory_assert.svh"

	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int CNT_BITS  = $clog2(SLOTS + 1);
	localparam int CMP_W     = (CNT_BITS > THR_W) ? CNT_BITS : THR_W;
	localparam int SUM_W     = ((SLOT_BITS > CNT_BITS) ? SLOT_BITS : CNT_BITS) + 1;
	localparam int SX_W      = (SLOT_BITS > SLOT_OUT_W) ? SLOT_BITS : SLOT_OUT_W;

	rcfd_state_t          state_q, state_d;
	logic [THR_W-1:0]     thr_q;
	logic [CNT_BITS-1:0]  held_q;
	logic [SLOT_BITS-1:0] oldest_q;
	logic [KEY_BITS-1:0]  req_key_q;
	logic                 req_ok_q;
	logic                 fin_found_q;
	logic [SLOT_BITS-1:0] fin_slot_q;
	logic [KEY_BITS-1:0]  fin_ev_key_q;
	logic                 rsp_valid_q;
	logic                 hit_q;
	logic                 present_q;
	logic [SLOT_OUT_W-1:0] slot_q;
	logic                 evicted_q;
	logic [KEY_BITS-1:0]  evicted_key_q;

	logic                 accept;
	logic                 capture;
	logic                 fire;
	logic                 cfg_wr;
	logic                 full;
	logic                 over;
	logic                 do_evict;
	logic                 do_insert;
	logic [SLOT_BITS-1:0] oldest_nx;
	logic [SLOT_BITS-1:0] oldest_ev;
	logic [CNT_BITS-1:0]  held_ev;
	logic [SUM_W-1:0]     where_sum;
	logic [SUM_W-1:0]     where_wrap;
	logic [SLOT_BITS-1:0] where_slot;
	logic [SLOT_BITS-1:0] slot_sel;
	logic [SX_W-1:0]      slot_x;

	// lookup chain, entry 0 is the chain head
	tok_flags_t           tok_flags  [SLOTS+1];
	logic [KEY_BITS-1:0]  tok_key    [SLOTS+1];
	logic [SLOT_BITS-1:0] tok_slot   [SLOTS+1];
	logic [KEY_BITS-1:0]  tok_ev_key [SLOTS+1];
	cell_ctl_t            cell_ctl   [SLOTS];

	// configuration write and read
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr && (paddr[2] == REG_EVICT_THRESHOLD)) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_EVICT_THRESHOLD: prdata = CFG_DW'(thr_q);
			default:             prdata = '0;
		endcase
	end

	// request handshake and chain head
	assign accept    = req_valid && !req_stall;
	assign capture   = (state_q == ST_WALK) && tok_flags[SLOTS].active;
	assign fire      = (state_q == ST_FINISH) && (!rsp_valid_q || !rsp_stall);

	assign tok_flags[0]  = '{active: accept, found: 1'b0};
	assign tok_key[0]    = region_key;
	assign tok_slot[0]   = '0;
	assign tok_ev_key[0] = '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			req_key_q <= region_key;
			req_ok_q  <= load_ok;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (tok_flags[SLOTS].active) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// token leaving the chain
	always_ff @(posedge clk) begin
		if (capture) begin
			fin_found_q  <= tok_flags[SLOTS].found;
			fin_slot_q   <= tok_slot[SLOTS];
			fin_ev_key_q <= tok_ev_key[SLOTS];
		end
	end

	// replacement decision and insertion slot
	assign full      = (held_q == CNT_BITS'(SLOTS));
	assign over      = CMP_W'(held_q) > CMP_W'(thr_q);
	assign do_insert = !fin_found_q && req_ok_q;
	assign do_evict  = do_insert && (held_q != '0) && (over || full);
	assign oldest_nx = (oldest_q == SLOT_BITS'(SLOTS - 1)) ? '0 : oldest_q + 1'b1;
	assign oldest_ev = do_evict ? oldest_nx : oldest_q;
	assign held_ev   = do_evict ? held_q - 1'b1 : held_q;
	assign where_sum = SUM_W'(oldest_ev) + SUM_W'(held_ev);
	assign where_wrap = (where_sum >= SUM_W'(SLOTS)) ? where_sum - SUM_W'(SLOTS) : where_sum;
	assign where_slot = where_wrap[SLOT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= '0;
			oldest_q <= '0;
		end else if (fire) begin
			held_q   <= held_ev + CNT_BITS'(do_insert);
			oldest_q <= oldest_ev;
		end
	end

	// cell chain
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		assign cell_ctl[i].write     = fire && do_insert && (where_slot == SLOT_BITS'(i));
		assign cell_ctl[i].clear     = fire && do_evict && (oldest_q == SLOT_BITS'(i));
		assign cell_ctl[i].is_oldest = (oldest_q == SLOT_BITS'(i));

		rcfd_cell #(
			.KEY_BITS  (KEY_BITS),
			.SLOT_BITS (SLOT_BITS),
			.IDX       (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (cell_ctl[i]),
			.wr_key     (req_key_q),
			.flags_in   (tok_flags[i]),
			.key_in     (tok_key[i]),
			.slot_in    (tok_slot[i]),
			.ev_key_in  (tok_ev_key[i]),
			.flags_out  (tok_flags[i+1]),
			.key_out    (tok_key[i+1]),
			.slot_out   (tok_slot[i+1]),
			.ev_key_out (tok_ev_key[i+1])
		);
	end

	// result register
	assign slot_sel = fin_found_q ? fin_slot_q : (do_insert ? where_slot : '0);
	assign slot_x   = SX_W'(slot_sel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			hit_q         <= fin_found_q;
			present_q     <= fin_found_q || req_ok_q;
			slot_q        <= slot_x[SLOT_OUT_W-1:0];
			evicted_q     <= do_evict;
			evicted_key_q <= do_evict ? fin_ev_key_q : '0;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign hit         = hit_q;
	assign present     = present_q;
	assign slot        = slot_q;
	assign evicted     = evicted_q;
	assign evicted_key = evicted_key_q;

	// checks
	`RCFD_ASSERT_NOW(a_held_bound, 1'b1, held_q <= CNT_BITS'(SLOTS), "held count beyond slot count")
	`RCFD_ASSERT_NOW(a_tok_end_walk, tok_flags[SLOTS].active, state_q == ST_WALK, "token left chain outside walk")
	`RCFD_ASSERT_NEXT(a_accept_walk, accept, state_q == ST_WALK, "accepted request did not start a walk")
	`RCFD_ASSERT_NOW(a_hit_no_evict, rsp_valid_q && hit_q, present_q && !evicted_q, "hit with eviction or not present")
	`RCFD_ASSERT_NEXT(a_fire_result, fire, rsp_valid_q && (state_q == ST_IDLE), "finished request without result")

endmodule
